>>> src/wsrch_pkg.sv
package wsrch_pkg;

  // Default build size
  localparam int PATTERN_MAX_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;

  // Register file geometry: 64-bit registers at byte address 8*i
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int REG_IDX_W = 3;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int MIDX_W  = 16;
  localparam int LEN_W   = 5;
  localparam int WIN_W   = 16;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;

  // Register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_WINDOW_START   = 3'd3,
    REG_WINDOW_END     = 3'd4
  } reg_idx_t;

  // One result item
  typedef struct packed {
    logic [MIDX_W-1:0] match_index;
    logic              found;
  } result_t;

  // Per-cycle control handed to every match cell
  typedef struct packed {
    logic adv;        // an item is accepted this cycle
    logic clear;      // that item ends the text
    logic in_window;  // its position lies in the search window
  } cell_ctrl_t;

endpackage

>>> src/wsrch_cell.sv
module wsrch_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  wsrch_pkg::cell_ctrl_t        ctrl,
  input  logic                         active,
  input  logic [wsrch_pkg::BYTE_W-1:0] pat_byte,
  input  logic [wsrch_pkg::BYTE_W-1:0] text_byte,
  input  logic                         match_prev,
  output logic                         match,
  output logic                         match_next
);

  // Extend the neighbour's partial match by this cell's pattern byte
  always_comb begin
    if (ctrl.in_window) begin
      match_next = match_prev & active & (pat_byte == text_byte);
    end else begin
      match_next = 1'b0;
    end
  end

  // Hold between items; drop at the end of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.adv) begin
      match <= ctrl.clear ? 1'b0 : match_next;
    end
  end

endmodule

>>> src/wsrch_skid.sv
module wsrch_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wsrch_pkg::result_t   push_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsrch_pkg::result_t   out_data
);

  logic               skid_valid;
  wsrch_pkg::result_t skid_data;
  logic               pop;

  assign pop   = out_valid & out_ready;
  assign space = ~skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> src/windowed_substring_search_core.sv
// Windowed first-occurrence substring search. Text arrives one byte per item on the s_ side
// (tlast marks the final byte); one item is taken every clock cycle while s_tready is high,
// each updating a row of PATTERN_MAX match cells that pass a shift-and match bit
// from neighbour to neighbour. Exactly one result per text leaves on the m_ side: at the
// first complete match inside the window [window_start, window_end) (window_end of zero
// means open-ended), or with found clear on the last byte. Results go through an output
// register with a one-entry skid, so input stalls only when two results wait downstream.
// Registers must be written over APB only while no text is in progress; the core never checks.
module windowed_substring_search_core #(
  parameter int PATTERN_MAX = wsrch_pkg::PATTERN_MAX_DEF,
  parameter int INDEX_BITS  = wsrch_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wsrch_pkg::ADDR_W-1:0]      paddr,
  input  logic [wsrch_pkg::DATA_W-1:0]      pwdata,
  output logic [wsrch_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  // Text input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wsrch_pkg::TDATA_IN_W-1:0]  s_tdata,  // [7:0] text_byte
  input  logic                              s_tlast,  // last
  // Result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wsrch_pkg::TDATA_OUT_W-1:0] m_tdata   // [0] found, [16:1] match_index, [23:17] 0
);

  localparam int LW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PW  = INDEX_BITS + 1;
  localparam int CW  = (PW > wsrch_pkg::WIN_W + 1) ? PW : wsrch_pkg::WIN_W + 1;

  // Configuration registers
  logic [wsrch_pkg::DATA_W-1:0] pattern_low;
  logic [wsrch_pkg::DATA_W-1:0] pattern_high;
  logic [wsrch_pkg::LEN_W-1:0]  pattern_length;
  logic [wsrch_pkg::WIN_W-1:0]  window_start;
  logic [wsrch_pkg::WIN_W-1:0]  window_end;

  logic                          cfg_wr;
  logic [wsrch_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[wsrch_pkg::ADDR_W-1:3];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= wsrch_pkg::LEN_W'(1);
      window_start   <= '0;
      window_end     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wsrch_pkg::REG_PATTERN_LOW:    pattern_low    <= pwdata;
        wsrch_pkg::REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        wsrch_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[wsrch_pkg::LEN_W-1:0];
        wsrch_pkg::REG_WINDOW_START:   window_start   <= pwdata[wsrch_pkg::WIN_W-1:0];
        wsrch_pkg::REG_WINDOW_END:     window_end     <= pwdata[wsrch_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_idx)
      wsrch_pkg::REG_PATTERN_LOW:    prdata = pattern_low;
      wsrch_pkg::REG_PATTERN_HIGH:   prdata = pattern_high;
      wsrch_pkg::REG_PATTERN_LENGTH: prdata = wsrch_pkg::DATA_W'(pattern_length);
      wsrch_pkg::REG_WINDOW_START:   prdata = wsrch_pkg::DATA_W'(window_start);
      wsrch_pkg::REG_WINDOW_END:     prdata = wsrch_pkg::DATA_W'(window_end);
      default:                       prdata = '0;
    endcase
  end

  // Effective pattern length, clamped to 1..PATTERN_MAX
  logic [wsrch_pkg::LEN_W-1:0] len_eff;
  logic [wsrch_pkg::LEN_W-1:0] len_m1_full;
  logic [LW-1:0]               len_m1;

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = wsrch_pkg::LEN_W'(1);
    end else if (pattern_length > wsrch_pkg::LEN_W'(PATTERN_MAX)) begin
      len_eff = wsrch_pkg::LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign len_m1_full = len_eff - wsrch_pkg::LEN_W'(1);
  assign len_m1      = len_m1_full[LW-1:0];

  // Text state
  logic [PW-1:0] position;
  logic          reported;
  logic          accept;
  logic          in_window;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] wstart_ext;
  logic [CW-1:0] wend_ext;

  assign accept     = s_tvalid & s_tready;
  assign pos_ext    = CW'(position);
  assign wstart_ext = CW'(window_start);
  assign wend_ext   = CW'(window_end);
  assign in_window  = ~position[INDEX_BITS] && (pos_ext >= wstart_ext) &&
                      ((window_end == '0) || (pos_ext < wend_ext));

  // Row of match cells
  wsrch_pkg::cell_ctrl_t  ctrl;
  logic [PATTERN_MAX-1:0] match_vec;
  logic [PATTERN_MAX-1:0] match_vec_next;
  logic [2*wsrch_pkg::DATA_W-1:0] pattern_all;

  assign ctrl.adv       = accept;
  assign ctrl.clear     = s_tlast;
  assign ctrl.in_window = in_window;
  assign pattern_all    = {pattern_high, pattern_low};

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic prev;
    logic active;

    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_vec[i-1];
    end

    assign active = (wsrch_pkg::LEN_W'(i) < len_eff);

    wsrch_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .active     (active),
      .pat_byte   (pattern_all[wsrch_pkg::BYTE_W*i +: wsrch_pkg::BYTE_W]),
      .text_byte  (s_tdata[wsrch_pkg::BYTE_W-1:0]),
      .match_prev (prev),
      .match      (match_vec[i]),
      .match_next (match_vec_next[i])
    );
  end

  // Result decision
  logic               hit;
  logic               push;
  logic [CW-1:0]      start_pos;
  wsrch_pkg::result_t res;

  assign hit       = in_window & match_vec_next[len_m1];
  assign push      = accept & ~reported & (hit | s_tlast);
  assign start_pos = pos_ext - CW'(len_m1_full);

  always_comb begin
    res.found       = hit;
    res.match_index = hit ? start_pos[wsrch_pkg::MIDX_W-1:0] : '0;
  end

  // Advance position (saturating), mark the answer, clear at end of text
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        position <= '0;
        reported <= 1'b0;
      end else begin
        if (!position[INDEX_BITS]) begin
          position <= position + PW'(1);
        end
        if (push) begin
          reported <= 1'b1;
        end
      end
    end
  end

  // Output register and skid
  wsrch_pkg::result_t out_res;

  wsrch_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = wsrch_pkg::TDATA_OUT_W'({out_res.match_index, out_res.found});

endmodule

>>> sim/tb_windowed_substring_search_core.sv
module tb_windowed_substring_search_core;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 38;
  localparam int RANDOM_PHASES   = 16;
  localparam int RESULT_W        = $bits(wsrch_pkg::result_t);

  localparam logic [wsrch_pkg::REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [wsrch_pkg::REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [16:0]                     POS_LIMIT       = 17'h10000;

  // Shift-and predictor of the first match per text, plus the answers still owed
  class match_scoreboard;
    logic [wsrch_pkg::DATA_W-1:0]          pat_lo;
    logic [wsrch_pkg::DATA_W-1:0]          pat_hi;
    logic [wsrch_pkg::LEN_W-1:0]           pat_len;
    logic [wsrch_pkg::WIN_W-1:0]           win_start;
    logic [wsrch_pkg::WIN_W-1:0]           win_end;
    logic [wsrch_pkg::PATTERN_MAX_DEF-1:0] match_bits;
    logic [16:0]                           text_pos;
    bit                                    answered;
    wsrch_pkg::result_t                    expected_answers[$];
    int                                    errors;

    function new();
      pat_lo    = '0;
      pat_hi    = '0;
      pat_len   = 5'd1;
      win_start = '0;
      win_end   = '0;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      match_bits = '0;
      text_pos   = '0;
      answered   = 1'b0;
    endfunction

    function void write_reg(logic [wsrch_pkg::REG_IDX_W-1:0] idx,
                            logic [wsrch_pkg::DATA_W-1:0] value);
      case (idx)
        wsrch_pkg::REG_PATTERN_LOW:    pat_lo    = value;
        wsrch_pkg::REG_PATTERN_HIGH:   pat_hi    = value;
        wsrch_pkg::REG_PATTERN_LENGTH: pat_len   = value[wsrch_pkg::LEN_W-1:0];
        wsrch_pkg::REG_WINDOW_START:   win_start = value[wsrch_pkg::WIN_W-1:0];
        wsrch_pkg::REG_WINDOW_END:     win_end   = value[wsrch_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the programmed length to 1..PATTERN_MAX
    function int unsigned span();
      if (pat_len == 0) return 1;
      if (pat_len > wsrch_pkg::PATTERN_MAX_DEF) return wsrch_pkg::PATTERN_MAX_DEF;
      return 32'(pat_len);
    endfunction

    function logic [wsrch_pkg::BYTE_W-1:0] pat_byte(int unsigned i);
      if (i < 8) return pat_lo[i*8 +: 8];
      return pat_hi[(i-8)*8 +: 8];
    endfunction

    // Note one accepted text item and queue the answer it causes, if any
    function void take_text_byte(logic [wsrch_pkg::BYTE_W-1:0] txt, logic is_final);
      int unsigned                           n;
      int unsigned                           i;
      logic [16:0]                           p;
      logic [wsrch_pkg::PATTERN_MAX_DEF-1:0] hits;
      bit                                    in_win;
      wsrch_pkg::result_t                    ans;
      n      = span();
      p      = text_pos;
      hits   = '0;
      in_win = (p < POS_LIMIT) && (p >= {1'b0, win_start}) &&
               (win_end == 0 || p < {1'b0, win_end});
      if (in_win) begin
        for (i = 0; i < n; i++)
          if (pat_byte(i) == txt) hits[i] = 1'b1;
        match_bits = {match_bits[wsrch_pkg::PATTERN_MAX_DEF-2:0], 1'b1} & hits;
      end else begin
        match_bits = '0;
      end
      if (!answered) begin
        if (in_win && match_bits[n-1]) begin
          ans.found       = 1'b1;
          ans.match_index = p[wsrch_pkg::MIDX_W-1:0] - wsrch_pkg::MIDX_W'(n - 1);
          answered        = 1'b1;
          expected_answers.push_back(ans);
        end else if (is_final) begin
          ans.found       = 1'b0;
          ans.match_index = '0;
          expected_answers.push_back(ans);
        end
      end
      if (p < POS_LIMIT) text_pos = p + 17'd1;
      if (is_final) restart();
    endfunction

    // Compare one accepted result with the oldest answer owed
    function void check_answer(logic [wsrch_pkg::TDATA_OUT_W-1:0] data);
      wsrch_pkg::result_t want;
      wsrch_pkg::result_t got;
      got = data[RESULT_W-1:0];
      if (expected_answers.size() == 0) begin
        $display("%0t: result with none owed: found %0d match_index %0d",
                 $time, got.found, got.match_index);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.match_index !== want.match_index) begin
        $display("%0t: match_index expected %0d got %0d",
                 $time, want.match_index, got.match_index);
        errors++;
      end
      if (data[wsrch_pkg::TDATA_OUT_W-1:RESULT_W] !== '0) begin
        $display("%0t: tdata padding expected 0 got %0h",
                 $time, data[wsrch_pkg::TDATA_OUT_W-1:RESULT_W]);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [wsrch_pkg::ADDR_W-1:0]      paddr;
  logic [wsrch_pkg::DATA_W-1:0]      pwdata;
  logic [wsrch_pkg::DATA_W-1:0]      prdata;
  logic                              pready;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [wsrch_pkg::TDATA_IN_W-1:0]  s_tdata;   // [7:0] text_byte
  logic                              s_tlast;   // last
  logic                              m_tvalid;
  logic                              m_tready;
  logic [wsrch_pkg::TDATA_OUT_W-1:0] m_tdata;   // [0] found, [16:1] match_index, [23:17] zero

  match_scoreboard sb = new();

  int          src_idle_pct;
  int          sink_stall_pct;
  bit          hold_req;
  int          quiet_cycles = 0;
  logic [7:0]  text_buf[$];
  logic [7:0]  alpha[4];

  windowed_substring_search_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Drain results; stall at random, or hold off for a long stretch on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_answer(m_tdata);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Setup and access cycle; psel stays up so writes can follow back to back
  task automatic apb_write(logic [wsrch_pkg::REG_IDX_W-1:0] idx,
                           logic [wsrch_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(logic [wsrch_pkg::DATA_W-1:0] lo, logic [wsrch_pkg::DATA_W-1:0] hi,
                           logic [wsrch_pkg::DATA_W-1:0] len, logic [wsrch_pkg::DATA_W-1:0] ws,
                           logic [wsrch_pkg::DATA_W-1:0] we);
    apb_write(wsrch_pkg::REG_PATTERN_LOW, lo);
    apb_write(wsrch_pkg::REG_PATTERN_HIGH, hi);
    apb_write(wsrch_pkg::REG_PATTERN_LENGTH, len);
    apb_write(wsrch_pkg::REG_WINDOW_START, ws);
    apb_write(wsrch_pkg::REG_WINDOW_END, we);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(logic [7:0] txt, logic is_final);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= txt;
    s_tlast  <= is_final;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_text_byte(txt, is_final);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++)
      send_item(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Wait until every owed answer is out and the block has settled
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly alphabet text with the pattern planted, else plain noise
  task automatic build_text(int unsigned max_len);
    int unsigned n;
    int unsigned plants;
    int unsigned at;
    int unsigned k;
    int unsigned j;
    n = $urandom_range(max_len, 1);
    text_buf.delete();
    if ($urandom_range(99, 0) < 70) begin
      for (k = 0; k < n; k++)
        text_buf.push_back(($urandom_range(99, 0) < 80) ? alpha[2'($urandom_range(3, 0))]
                                                         : 8'($urandom_range(255, 0)));
      plants = $urandom_range(2, 1);
      for (k = 0; k < plants; k++) begin
        at = $urandom_range(n - 1, 0);
        for (j = 0; j < sb.span() && at + j < n; j++)
          text_buf[at + j] = sb.pat_byte(j);
      end
    end else begin
      for (k = 0; k < n; k++) text_buf.push_back(8'($urandom_range(255, 0)));
    end
  endtask

  function automatic logic [wsrch_pkg::DATA_W-1:0] pattern_word(bit full_random);
    logic [wsrch_pkg::DATA_W-1:0] w;
    int                           k;
    for (k = 0; k < 8; k++)
      w[k*8 +: 8] = full_random ? 8'($urandom_range(255, 0))
                                : alpha[2'($urandom_range(3, 0))];
    return w;
  endfunction

  task automatic random_setup();
    logic [wsrch_pkg::LEN_W-1:0] len;
    logic [wsrch_pkg::WIN_W-1:0] ws;
    logic [wsrch_pkg::WIN_W-1:0] we;
    bit                          full_random;
    int                          r;
    int                          k;
    for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255, 0));
    full_random = ($urandom_range(3, 0) == 0);
    r = $urandom_range(9, 0);
    if (r == 0)      len = 5'd0;
    else if (r == 1) len = wsrch_pkg::LEN_W'($urandom_range(31, 17));
    else if (r == 2) len = 5'd16;
    else             len = wsrch_pkg::LEN_W'($urandom_range(6, 1));
    r  = $urandom_range(9, 0);
    ws = '0;
    we = '0;
    if (r >= 4 && r <= 6) begin
      ws = wsrch_pkg::WIN_W'($urandom_range(15, 0));
    end else if (r >= 7 && r <= 8) begin
      ws = wsrch_pkg::WIN_W'($urandom_range(15, 0));
      we = ws + wsrch_pkg::WIN_W'($urandom_range(30, 1));
    end else if (r == 9) begin
      ws = wsrch_pkg::WIN_W'($urandom_range(20, 1));
      we = wsrch_pkg::WIN_W'($urandom_range(ws, 1));
    end
    // Upper bits of the narrow registers carry noise the block must drop
    configure(pattern_word(full_random), pattern_word(full_random),
              {$urandom, 27'($urandom), len}, {$urandom, 16'($urandom), ws},
              {$urandom, 16'($urandom), we});
  endtask

  initial begin
    int          p;
    int          sent;
    int unsigned max_len;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero byte of length one, open window
    text_buf = '{8'h00};
    send_text();
    text_buf = '{8'hFF, 8'hFF};
    send_text();
    wait_drained();

    // Pattern that starts with a repeated byte, then bytes after the answer; spare index ignored
    apb_write(wsrch_pkg::REG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
              {64{1'b1}});
    configure(64'h0000_0000_0062_6161, {64{1'b1}}, 64'd3, 64'd0, 64'd0);
    text_buf = '{8'h61, 8'h61, 8'h61, 8'h62, 8'hFF, 8'h00};
    send_text();
    wait_drained();

    // Zero length acts as one; bytes outside the window cannot match
    configure(64'hFFFF_FFFF_FFFF_00FF, 64'd0, 64'd0, 64'd2, 64'd4);
    text_buf = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF};
    send_text();
    wait_drained();

    // Empty window with an over-long length
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd31, 64'd5, 64'd5);
    text_buf = '{8'hFF, 8'hFF, 8'hFF};
    send_text();

    // Random phases, cycling through the idling mixes
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      random_setup();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      max_len = (p % 5 == 0) ? 4 : $urandom_range(40, 8);
      // Short texts while the sink holds off fill the output stage
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_text(max_len);
        send_text();
        sent += text_buf.size();
      end
    end
    wait_drained();

    if (sb.expected_answers.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, sb.expected_answers.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
